[hw/rtl/robb_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package robb_pkg;

  localparam int COORD_FRAC_BITS = 12;

  localparam int COORD_W = 20;
  localparam int DIST_W  = 21;
  localparam int VEC_W   = 16;
  localparam int P_W     = 21;
  localparam int MF_W    = 32;
  localparam int ME_W    = 37;
  localparam int FV_W    = 34;
  localparam int EV_W    = 39;
  localparam int SUM_W   = 40;
  localparam int NUM_W   = 54;
  localparam int DEN_W   = 34;
  localparam int Q_W     = 21;

  localparam int PROJ_LAT = 4;
  localparam int DIV_LAT  = Q_W + 2;
  localparam int RES_LAT  = 4;
  localparam int PIPE_LAT = PROJ_LAT + DIV_LAT + RES_LAT;

  localparam logic signed [DIST_W-1:0] DIST_MAX = 21'sd1048575;
  localparam logic signed [DIST_W-1:0] DIST_MIN = -21'sd1048576;
  localparam logic signed [VEC_W-1:0]  VEC_ONE  = 16'sd16384;

  typedef enum logic [2:0] {
    REG_AXIS_X = 3'd0,
    REG_AXIS_Y = 3'd1,
    REG_AXIS_Z = 3'd2,
    REG_CENTER = 3'd3,
    REG_HALF   = 3'd4
  } reg_e;

  typedef struct packed {
    logic [2:0][47:0] axis;
    logic [59:0]      center;
    logic [59:0]      half;
  } cfg_t;

  // side data that rides along the divider pipeline
  typedef struct packed {
    logic [2:0][COORD_W-1:0] o;
    logic [2:0][VEC_W-1:0]   d;
    logic [2:0]              bnd;
    logic                    pmiss;
  } side_t;

  function automatic logic signed [VEC_W-1:0] axis_comp(cfg_t c, int a, int k);
    logic [47:0] w;
    w = c.axis[a];
    return $signed(w[16*k +: 16]);
  endfunction

endpackage
`default_nettype wire

[hw/rtl/robb_cfg.sv]
`timescale 1ns / 1ps
`default_nettype none
module robb_cfg
  import robb_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [5:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic [63:0]      prdata,
  output logic             pready,
  output cfg_t             cfg_o
);

  cfg_t cfg_q;
  logic wr;
  reg_e idx;

  assign wr     = psel && penable && pwrite;
  assign idx    = reg_e'(paddr[5:3]);
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.axis[0] <= 48'd16384;
      cfg_q.axis[1] <= 48'd16384 << 16;
      cfg_q.axis[2] <= 48'd16384 << 32;
      cfg_q.center  <= '0;
      cfg_q.half    <= {20'd4096, 20'd4096, 20'd4096};
    end else if (wr) begin
      case (idx)
        REG_AXIS_X: cfg_q.axis[0] <= pwdata[47:0];
        REG_AXIS_Y: cfg_q.axis[1] <= pwdata[47:0];
        REG_AXIS_Z: cfg_q.axis[2] <= pwdata[47:0];
        REG_CENTER: cfg_q.center  <= pwdata[59:0];
        REG_HALF:   cfg_q.half    <= pwdata[59:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_AXIS_X: prdata = {16'd0, cfg_q.axis[0]};
      REG_AXIS_Y: prdata = {16'd0, cfg_q.axis[1]};
      REG_AXIS_Z: prdata = {16'd0, cfg_q.axis[2]};
      REG_CENTER: prdata = {4'd0, cfg_q.center};
      REG_HALF:   prdata = {4'd0, cfg_q.half};
      default:    prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

[hw/rtl/robb_proj.sv]
`timescale 1ns / 1ps
`default_nettype none
module robb_proj
  import robb_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire cfg_t                 cfg_i,
  input  wire logic                 vld_i,
  input  wire logic [2:0][COORD_W-1:0] o_i,
  input  wire logic [2:0][VEC_W-1:0]   d_i,
  output logic                      vld_o,
  output side_t                     side_o,
  output logic [5:0][NUM_W-1:0]     num_o,
  output logic [5:0]                neg_o,
  output logic [2:0][DEN_W-1:0]     den_o
);

  logic [3:0] vld_q;

  // stage 1: centre minus origin
  logic signed [COORD_W-1:0] o1_q [3];
  logic signed [VEC_W-1:0]   d1_q [3];
  logic signed [P_W-1:0]     p1_q [3];
  // stage 2: products
  logic signed [COORD_W-1:0] o2_q [3];
  logic signed [VEC_W-1:0]   d2_q [3];
  logic signed [MF_W-1:0]    mf_q [3][3];
  logic signed [ME_W-1:0]    me_q [3][3];
  // stage 3: dot products
  logic signed [COORD_W-1:0] o3_q [3];
  logic signed [VEC_W-1:0]   d3_q [3];
  logic signed [FV_W-1:0]    fv_q [3];
  logic signed [EV_W-1:0]    ev_q [3];
  // stage 4: slab numerators
  side_t                  side_q;
  logic [5:0][NUM_W-1:0]  num_q;
  logic [5:0]             neg_q;
  logic [2:0][DEN_W-1:0]  den_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else         vld_q <= {vld_q[2:0], vld_i};
  end

  always_ff @(posedge clk_i) begin
    logic signed [COORD_W-1:0] c;
    for (int k = 0; k < 3; k++) begin
      c = $signed(cfg_i.center[20*k +: 20]);
      o1_q[k] <= $signed(o_i[k]);
      d1_q[k] <= $signed(d_i[k]);
      p1_q[k] <= P_W'(c) - P_W'($signed(o_i[k]));
    end
  end

  always_ff @(posedge clk_i) begin
    for (int a = 0; a < 3; a++) begin
      o2_q[a] <= o1_q[a];
      d2_q[a] <= d1_q[a];
      for (int k = 0; k < 3; k++) begin
        mf_q[a][k] <= MF_W'(axis_comp(cfg_i, a, k)) * MF_W'(d1_q[k]);
        me_q[a][k] <= ME_W'(axis_comp(cfg_i, a, k)) * ME_W'(p1_q[k]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int a = 0; a < 3; a++) begin
      o3_q[a] <= o2_q[a];
      d3_q[a] <= d2_q[a];
      fv_q[a] <= FV_W'(mf_q[a][0]) + FV_W'(mf_q[a][1]) + FV_W'(mf_q[a][2]);
      ev_q[a] <= EV_W'(me_q[a][0]) + EV_W'(me_q[a][1]) + EV_W'(me_q[a][2]);
    end
  end

  always_ff @(posedge clk_i) begin
    logic signed [SUM_W-1:0] sv, ev, sa, sb;
    logic signed [NUM_W-1:0] na, nb;
    logic pm;
    pm = 1'b0;
    for (int a = 0; a < 3; a++) begin
      sv = $signed({6'd0, cfg_i.half[20*a +: 20], 14'd0});
      ev = SUM_W'(ev_q[a]);
      sa = ev + sv;
      sb = ev - sv;
      na = $signed({sa, 14'd0});
      nb = $signed({sb, 14'd0});
      num_q[2*a]   <= sa[SUM_W-1] ? NUM_W'(-na) : NUM_W'(na);
      num_q[2*a+1] <= sb[SUM_W-1] ? NUM_W'(-nb) : NUM_W'(nb);
      neg_q[2*a]   <= sa[SUM_W-1] ^ fv_q[a][FV_W-1];
      neg_q[2*a+1] <= sb[SUM_W-1] ^ fv_q[a][FV_W-1];
      den_q[a]     <= fv_q[a][FV_W-1] ? DEN_W'(-fv_q[a]) : DEN_W'(fv_q[a]);
      side_q.bnd[a] <= (fv_q[a] != '0);
      // parallel slab with the origin outside it
      if (fv_q[a] == '0 && (ev > sv || ev < -sv)) pm = 1'b1;
      side_q.o[a] <= o3_q[a];
      side_q.d[a] <= d3_q[a];
    end
    side_q.pmiss <= pm;
  end

  assign vld_o  = vld_q[3];
  assign side_o = side_q;
  assign num_o  = num_q;
  assign neg_o  = neg_q;
  assign den_o  = den_q;

endmodule
`default_nettype wire

[hw/rtl/robb_div.sv]
`timescale 1ns / 1ps
`default_nettype none
// restoring divider, one quotient bit per stage, result saturated to DIST_W
module robb_div
  import robb_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     vld_i,
  input  wire logic [NUM_W-1:0]         num_i,
  input  wire logic [DEN_W-1:0]         den_i,
  input  wire logic                     neg_i,
  output logic                          vld_o,
  output logic signed [DIST_W-1:0]      q_o
);

  logic [Q_W:0]       vld_q;
  logic [NUM_W-1:0]   rem_q [Q_W+1];
  logic [DEN_W-1:0]   den_q [Q_W+1];
  logic [Q_W-1:0]     quo_q [Q_W+1];
  logic               neg_q [Q_W+1];
  logic               ovf_q [Q_W+1];
  logic               vout_q;
  logic signed [DIST_W-1:0] q_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      vout_q <= 1'b0;
    end else begin
      vld_q  <= {vld_q[Q_W-1:0], vld_i};
      vout_q <= vld_q[Q_W];
    end
  end

  // entry stage: quotient too large for Q_W bits
  always_ff @(posedge clk_i) begin
    rem_q[0] <= num_i;
    den_q[0] <= den_i;
    quo_q[0] <= '0;
    neg_q[0] <= neg_i;
    ovf_q[0] <= ({1'b0, num_i} >= ({(NUM_W+1-DEN_W)'(0), den_i} << Q_W));
  end

  for (genvar k = 1; k <= Q_W; k++) begin : g_step
    localparam int J = Q_W - k;
    logic [NUM_W:0] sh;
    assign sh = {(NUM_W+1-DEN_W)'(0), den_q[k-1]} << J;
    always_ff @(posedge clk_i) begin
      den_q[k] <= den_q[k-1];
      neg_q[k] <= neg_q[k-1];
      ovf_q[k] <= ovf_q[k-1];
      if ({1'b0, rem_q[k-1]} >= sh) begin
        rem_q[k] <= NUM_W'({1'b0, rem_q[k-1]} - sh);
        quo_q[k] <= quo_q[k-1] | (Q_W'(1) << J);
      end else begin
        rem_q[k] <= rem_q[k-1];
        quo_q[k] <= quo_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    logic [Q_W-1:0] m;
    m = quo_q[Q_W];
    if (!neg_q[Q_W]) begin
      if (ovf_q[Q_W] || m[Q_W-1]) q_q <= DIST_MAX;
      else                        q_q <= $signed(m);
    end else begin
      if (ovf_q[Q_W] || (m[Q_W-1] && m[Q_W-2:0] != '0)) q_q <= DIST_MIN;
      else                                               q_q <= -$signed(m);
    end
  end

  assign vld_o = vout_q;
  assign q_o   = q_q;

endmodule
`default_nettype wire

[hw/rtl/robb_resolve.sv]
`timescale 1ns / 1ps
`default_nettype none
module robb_resolve
  import robb_pkg::*;
#(
  parameter int CoordFracBits = COORD_FRAC_BITS
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire cfg_t                    cfg_i,
  input  wire logic                    vld_i,
  input  wire side_t                   side_i,
  input  wire logic [5:0][DIST_W-1:0]  t_i,
  output logic                         vld_o,
  output logic                         hit_o,
  output logic signed [DIST_W-1:0]     dist_o,
  output logic [2:0][COORD_W-1:0]      pt_o,
  output logic [2:0][VEC_W-1:0]        nrm_o
);

  localparam logic signed [DIST_W-1:0] MissDist = -(DIST_W'(1) << CoordFracBits);

  function automatic logic signed [VEC_W-1:0] neg16(logic signed [VEC_W-1:0] v);
    return (v == VEC_W'(1) << (VEC_W-1)) ? VEC_W'((1 << (VEC_W-1)) - 1) : -v;
  endfunction

  logic [3:0] vld_q;

  // stage 1: entry and exit
  side_t                     s1_q;
  logic signed [DIST_W-1:0]  t1_q [6];
  logic signed [DIST_W-1:0]  tmin1_q, tmax1_q;
  // stage 2: decision and normal
  logic                      hit2_q;
  logic signed [DIST_W-1:0]  tr2_q;
  logic signed [COORD_W-1:0] o2_q [3];
  logic signed [VEC_W-1:0]   d2_q [3];
  logic [2:0][VEC_W-1:0]     n2_q;
  // stage 3: direction times distance
  logic                      hit3_q;
  logic signed [DIST_W-1:0]  tr3_q;
  logic signed [COORD_W-1:0] o3_q [3];
  logic signed [ME_W-1:0]    m3_q [3];
  logic [2:0][VEC_W-1:0]     n3_q;
  // stage 4: result
  logic                      hit_q;
  logic signed [DIST_W-1:0]  dist_q;
  logic [2:0][COORD_W-1:0]   pt_q;
  logic [2:0][VEC_W-1:0]     nrm_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else         vld_q <= {vld_q[2:0], vld_i};
  end

  always_ff @(posedge clk_i) begin
    logic signed [DIST_W-1:0] ta, tb, lo, hi, mn, mx;
    mn = DIST_MIN;
    mx = DIST_MAX;
    for (int a = 0; a < 3; a++) begin
      ta = $signed(t_i[2*a]);
      tb = $signed(t_i[2*a+1]);
      lo = (ta < tb) ? ta : tb;
      hi = (ta > tb) ? ta : tb;
      if (side_i.bnd[a] && lo > mn) mn = lo;
      if (side_i.bnd[a] && hi < mx) mx = hi;
    end
    for (int i = 0; i < 6; i++) t1_q[i] <= $signed(t_i[i]);
    tmin1_q <= mn;
    tmax1_q <= mx;
    s1_q    <= side_i;
  end

  always_ff @(posedge clk_i) begin
    logic signed [DIST_W-1:0] tr;
    logic [2:0][VEC_W-1:0] n;
    tr = (tmin1_q < 0) ? tmax1_q : tmin1_q;
    n  = {VEC_ONE, VEC_W'(0), VEC_W'(0)};
    // the last matching plane wins
    for (int i = 0; i < 6; i++) begin
      if (s1_q.bnd[i/2] && t1_q[i] == tr) begin
        for (int k = 0; k < 3; k++)
          n[k] = (i % 2 == 1) ? neg16(axis_comp(cfg_i, i/2, k)) : axis_comp(cfg_i, i/2, k);
      end
    end
    hit2_q <= !s1_q.pmiss && !(tmax1_q < 0) && !(tmin1_q > tmax1_q);
    tr2_q  <= tr;
    n2_q   <= n;
    for (int k = 0; k < 3; k++) begin
      o2_q[k] <= $signed(s1_q.o[k]);
      d2_q[k] <= $signed(s1_q.d[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    hit3_q <= hit2_q;
    tr3_q  <= tr2_q;
    n3_q   <= n2_q;
    for (int k = 0; k < 3; k++) begin
      o3_q[k] <= o2_q[k];
      m3_q[k] <= ME_W'(d2_q[k]) * ME_W'(tr2_q);
    end
  end

  always_ff @(posedge clk_i) begin
    logic signed [ME_W:0]    r;
    logic signed [ME_W-13:0] s;
    hit_q <= hit3_q;
    if (hit3_q) begin
      dist_q <= tr3_q;
      nrm_q  <= n3_q;
      for (int k = 0; k < 3; k++) begin
        // round half up to the coordinate grid
        r = (ME_W+1)'(m3_q[k]) + (ME_W+1)'(8192);
        s = (ME_W-12)'(r >>> 14) + (ME_W-12)'(o3_q[k]);
        if (s > (ME_W-12)'(524287))       pt_q[k] <= COORD_W'(524287);
        else if (s < -(ME_W-12)'(524288)) pt_q[k] <= COORD_W'(1) << (COORD_W-1);
        else                              pt_q[k] <= COORD_W'(s);
      end
    end else begin
      dist_q <= MissDist;
      nrm_q  <= {VEC_ONE, VEC_W'(0), VEC_W'(0)};
      pt_q   <= '0;
    end
  end

  assign vld_o  = vld_q[3];
  assign hit_o  = hit_q;
  assign dist_o = dist_q;
  assign pt_o   = pt_q;
  assign nrm_o  = nrm_q;

endmodule
`default_nettype wire

[hw/rtl/ray_obb_slab_intersection_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// Ray against oriented box. One ray is taken in every cycle (busy stays low)
// and its result reaches done_o through 4 projection stages, a 23-stage
// restoring divider (one quotient bit per stage, six in parallel for the
// slab bounds) and 4 resolve stages. The receiver cannot stall; each result
// is shown for one cycle only. Box registers sit on the 64-bit APB port at
// 8-byte strides and must only be written while no ray is in flight.
module ray_obb_slab_intersection_top
  import robb_pkg::*;
#(
  parameter int CoordFracBits = COORD_FRAC_BITS
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [5:0]         paddr,
  input  wire logic [63:0]        pwdata,
  output logic [63:0]             prdata,
  output logic                    pready,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic signed [19:0] ray_origin_x_i,
  input  wire logic signed [19:0] ray_origin_y_i,
  input  wire logic signed [19:0] ray_origin_z_i,
  input  wire logic signed [15:0] ray_dir_x_i,
  input  wire logic signed [15:0] ray_dir_y_i,
  input  wire logic signed [15:0] ray_dir_z_i,
  output logic                    done_o,
  output logic                    hit_o,
  output logic signed [20:0]      hit_distance_o,
  output logic signed [19:0]      hit_point_x_o,
  output logic signed [19:0]      hit_point_y_o,
  output logic signed [19:0]      hit_point_z_o,
  output logic signed [15:0]      hit_normal_x_o,
  output logic signed [15:0]      hit_normal_y_o,
  output logic signed [15:0]      hit_normal_z_o
);

  cfg_t                   cfg;
  logic                   pv;
  side_t                  pside;
  logic [5:0][NUM_W-1:0]  num;
  logic [5:0]             neg;
  logic [2:0][DEN_W-1:0]  den;
  logic [5:0]             dv;
  logic [5:0][DIST_W-1:0] t;
  side_t                  side_q [DIV_LAT];
  logic [2:0][COORD_W-1:0] pt;
  logic [2:0][VEC_W-1:0]   nrm;

  assign busy = 1'b0;

  robb_cfg u_cfg (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata,
    .prdata, .pready, .cfg_o(cfg)
  );

  robb_proj u_proj (
    .clk_i, .rst_ni, .cfg_i(cfg),
    .vld_i (start && !busy),
    .o_i   ({ray_origin_z_i, ray_origin_y_i, ray_origin_x_i}),
    .d_i   ({ray_dir_z_i, ray_dir_y_i, ray_dir_x_i}),
    .vld_o (pv), .side_o(pside), .num_o(num), .neg_o(neg), .den_o(den)
  );

  for (genvar i = 0; i < 6; i++) begin : g_div
    robb_div u_div (
      .clk_i, .rst_ni, .vld_i(pv), .num_i(num[i]), .den_i(den[i/2]),
      .neg_i(neg[i]), .vld_o(dv[i]), .q_o(t[i])
    );
  end

  always_ff @(posedge clk_i) begin
    side_q[0] <= pside;
    for (int i = 1; i < DIV_LAT; i++) side_q[i] <= side_q[i-1];
  end

  robb_resolve #(.CoordFracBits(CoordFracBits)) u_res (
    .clk_i, .rst_ni, .cfg_i(cfg), .vld_i(&dv), .side_i(side_q[DIV_LAT-1]),
    .t_i(t), .vld_o(done_o), .hit_o, .dist_o(hit_distance_o), .pt_o(pt), .nrm_o(nrm)
  );

  assign hit_point_x_o  = $signed(pt[0]);
  assign hit_point_y_o  = $signed(pt[1]);
  assign hit_point_z_o  = $signed(pt[2]);
  assign hit_normal_x_o = $signed(nrm[0]);
  assign hit_normal_y_o = $signed(nrm[1]);
  assign hit_normal_z_o = $signed(nrm[2]);

endmodule
`default_nettype wire

[hw/rtl/robb_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
module robb_checker
  import robb_pkg::*;
(
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               start,
  input wire logic               busy,
  input wire logic               pready,
  input wire logic               done_o,
  input wire logic               hit_o,
  input wire logic signed [20:0] hit_distance_o,
  input wire logic signed [19:0] hit_point_x_o,
  input wire logic signed [15:0] hit_normal_x_o,
  input wire logic signed [15:0] hit_normal_z_o
);

  // every result traces back to an item taken in by the pipeline
  a_done_has_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, PIPE_LAT))
    else $error("result without an item");

  a_miss_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !hit_o |-> hit_point_x_o == 0 && hit_normal_x_o == 0 &&
                         hit_normal_z_o == VEC_ONE && hit_distance_o < 0)
    else $error("miss result malformed");

  a_hit_ahead: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && hit_o |-> hit_distance_o >= 0)
    else $error("hit behind the origin");

  a_no_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy && pready)
    else $error("block stalled");

endmodule

bind ray_obb_slab_intersection_top robb_checker u_robb_checker (
  .clk_i, .rst_ni, .start, .busy, .pready, .done_o, .hit_o, .hit_distance_o,
  .hit_point_x_o, .hit_normal_x_o, .hit_normal_z_o
);
`default_nettype wire
